/* src/ba_pkg.sv */
// buddy allocator package: payload structs and codes
package ba_pkg;

  typedef struct packed {
    logic        action;
    logic [15:0] request_bytes;
    logic [13:0] free_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] block_offset;
    logic [14:0] used_bytes;
  } out_word_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

endpackage

/* src/ba_ram.sv */
// generic single-port-write ram with registered read
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/buddy_allocator_core.sv */
// buddy allocator top level: control sequencer around link and level memories
//
// Usage: raise start with in_word while busy is low; the word is taken at that
// edge and busy goes high. When the work is done out_valid pulses for one cycle
// with out_word (status, block offset, used bytes) and busy drops in the same
// cycle, so the next word may be presented then.
// Free lists are linked through a link ram (one entry per minimum block) and an
// allocated-level ram; both have a registered read. Level heads are registers.
// An alloc searches the level heads upward from the wanted level, pops the first
// free block it finds and splits it down to the wanted level. A free clears the
// allocated-level entry, then walks the free list of each level it tries, one
// node read at a time, to unlink the buddy and merge upward; the block is pushed
// at the level where no buddy is found. The lists hold at most NUM_BLOCKS nodes
// together.
// After reset a clearing pass writes zero into every allocated-level entry and
// NIL into every link entry, with busy high. The receiver cannot stall:
// out_valid is a single-cycle strobe.
module buddy_allocator_core #(
  parameter int NUM_BLOCKS = 256,
  parameter int MIN_BLOCK  = 64,
  parameter int LEVELS     = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ba_pkg::in_word_t  in_word,
  output logic              out_valid,
  output ba_pkg::out_word_t out_word
);
  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int NW = IW + 1;
  localparam int LW = $clog2(LEVELS + 1);
  localparam int MW = $clog2(MIN_BLOCK) + 1;
  localparam int SH = $clog2(MIN_BLOCK);
  localparam logic [NW-1:0] NIL = NW'(NUM_BLOCKS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FIND = 4'd2;
  localparam logic [3:0] S_POP  = 4'd3;
  localparam logic [3:0] S_SPLT = 4'd4;
  localparam logic [3:0] S_FCHK = 4'd5;
  localparam logic [3:0] S_MLVL = 4'd6;
  localparam logic [3:0] S_WALK = 4'd7;
  localparam logic [3:0] S_WRD  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_MRG  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [NW-1:0] heads_r [LEVELS];
  logic [NW-1:0] heads_nxt [LEVELS];
  logic [IW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] want_r, want_nxt, cur_r, cur_nxt;
  logic [NW-1:0] walk_r, walk_nxt, prev_r, prev_nxt;
  logic [NW-1:0] bud_r, bud_nxt;
  logic [14:0]   used_r, used_nxt;
  logic [IW:0]   clr_r, clr_nxt;
  ba_pkg::in_word_t  in_r, in_nxt;
  ba_pkg::out_word_t res_r, res_nxt;
  logic              ov_r, ov_nxt;

  logic          ln_we, al_we;
  logic [IW-1:0] ln_wa, ln_ra, al_wa, al_ra;
  logic [NW-1:0] ln_wd, ln_rd;
  logic [LW-1:0] al_wd, al_rd;

  ba_ram #(.WIDTH(NW), .DEPTH(NUM_BLOCKS)) u_link (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
  ba_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_alvl (
    .clk(clk), .we(al_we), .waddr(al_wa), .wdata(al_wd), .raddr(al_ra), .rdata(al_rd));

  function automatic logic [31:0] lbytes(input logic [LW-1:0] l);
    return 32'(MIN_BLOCK) << l;
  endfunction

  logic [16:0]   req_eff;
  logic [LW-1:0] want_c;
  logic [31:0]   qraw;
  logic [IW-1:0] bud_idx;
  logic [31:0]   upper;

  always_comb begin
    req_eff = (in_word.request_bytes == 16'd0) ? 17'd1 : {1'b0, in_word.request_bytes};
    want_c  = LW'(LEVELS);
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((32'(MIN_BLOCK) << l) >= 32'(req_eff)) begin
        want_c = LW'(l);
      end
    end
    qraw    = 32'(in_r.free_offset) >> SH;
    bud_idx = idx_r ^ IW'((32'd1 << cur_r));
    upper   = 32'(idx_r) + (32'd1 << (cur_r - LW'(1)));
  end

  always_comb begin
    state_nxt = state_r;
    heads_nxt = heads_r;
    idx_nxt   = idx_r;
    want_nxt  = want_r;
    cur_nxt   = cur_r;
    walk_nxt  = walk_r;
    prev_nxt  = prev_r;
    bud_nxt   = bud_r;
    used_nxt  = used_r;
    clr_nxt   = clr_r;
    in_nxt    = in_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = NIL; ln_ra = '0;
    al_we = 1'b0; al_wa = '0; al_wd = '0;  al_ra = '0;
    unique case (state_r)
      S_CLR: begin
        al_we = 1'b1;
        al_wa = clr_r[IW-1:0];
        ln_we = 1'b1;
        ln_wa = clr_r[IW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IW+1)'(NUM_BLOCKS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          in_nxt   = in_word;
          want_nxt = want_c;
          cur_nxt  = want_c;
          state_nxt = (in_word.action == ba_pkg::ACT_ALLOC) ? S_FIND : S_FCHK;
        end
      end
      S_FIND: begin
        if (cur_r >= LW'(LEVELS)) begin
          res_nxt = '{ba_pkg::ST_NOSPACE, 14'd0, used_r};
          state_nxt = S_DONE;
        end else if (heads_r[cur_r] == NIL) begin
          cur_nxt = cur_r + 1'b1;
        end else begin
          idx_nxt = heads_r[cur_r][IW-1:0];
          ln_ra   = heads_r[cur_r][IW-1:0];
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        heads_nxt[cur_r] = ln_rd;
        state_nxt = S_SPLT;
      end
      S_SPLT: begin
        if (cur_r > want_r) begin
          if (upper < 32'(NUM_BLOCKS)) begin
            ln_we = 1'b1;
            ln_wa = IW'(upper);
            ln_wd = heads_r[cur_r - LW'(1)];
            heads_nxt[cur_r - LW'(1)] = NW'(upper);
          end
          cur_nxt = cur_r - 1'b1;
        end else begin
          al_we = 1'b1;
          al_wa = idx_r;
          al_wd = want_r + 1'b1;
          used_nxt = used_r + 15'(lbytes(want_r));
          res_nxt  = '{ba_pkg::ST_DONE, 14'(32'(idx_r) * 32'(MIN_BLOCK)), 15'(used_r + 15'(lbytes(want_r)))};
          state_nxt = S_DONE;
        end
      end
      S_FCHK: begin
        if (in_r.free_offset[MW-2:0] != '0 && MIN_BLOCK > 1 || qraw >= 32'(NUM_BLOCKS)) begin
          res_nxt = '{ba_pkg::ST_IGNORED, 14'd0, used_r};
          state_nxt = S_DONE;
        end else begin
          idx_nxt = IW'(qraw);
          al_ra   = IW'(qraw);
          state_nxt = S_MLVL;
        end
      end
      S_MLVL: begin
        if (al_rd == '0) begin
          res_nxt = '{ba_pkg::ST_IGNORED, 14'd0, used_r};
          state_nxt = S_DONE;
        end else begin
          al_we = 1'b1;
          al_wa = idx_r;
          al_wd = '0;
          cur_nxt  = al_rd - 1'b1;
          used_nxt = used_r - 15'(lbytes(al_rd - 1'b1));
          state_nxt = S_MRG;
        end
      end
      S_MRG: begin
        if (cur_r + 1'b1 < LW'(LEVELS) && 32'(bud_idx) < 32'(NUM_BLOCKS) &&
            (32'(idx_r) ^ (32'd1 << cur_r)) < 32'(NUM_BLOCKS)) begin
          bud_nxt  = NW'(bud_idx);
          walk_nxt = heads_r[cur_r];
          prev_nxt = NIL;
          state_nxt = S_WALK;
        end else begin
          ln_we = 1'b1;
          ln_wa = idx_r;
          ln_wd = heads_r[cur_r];
          heads_nxt[cur_r] = NW'(idx_r);
          res_nxt = '{ba_pkg::ST_DONE, 14'd0, used_r};
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        if (walk_r == NIL) begin
          ln_we = 1'b1;
          ln_wa = idx_r;
          ln_wd = heads_r[cur_r];
          heads_nxt[cur_r] = NW'(idx_r);
          res_nxt = '{ba_pkg::ST_DONE, 14'd0, used_r};
          state_nxt = S_DONE;
        end else begin
          ln_ra = walk_r[IW-1:0];
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        if (walk_r == bud_r) begin
          if (prev_r == NIL) begin
            heads_nxt[cur_r] = ln_rd;
          end else begin
            ln_we = 1'b1;
            ln_wa = prev_r[IW-1:0];
            ln_wd = ln_rd;
          end
          if (bud_r[IW-1:0] < idx_r) idx_nxt = bud_r[IW-1:0];
          cur_nxt = cur_r + 1'b1;
          state_nxt = S_MRG;
        end else begin
          prev_nxt = walk_r;
          walk_nxt = ln_rd;
          state_nxt = S_WALK;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
      for (int l = 0; l < LEVELS; l++) heads_r[l] <= (l == LEVELS - 1) ? '0 : NIL;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
      heads_r <= heads_nxt;
    end
    idx_r  <= idx_nxt;
    want_r <= want_nxt;
    cur_r  <= cur_nxt;
    walk_r <= walk_nxt;
    prev_r <= prev_nxt;
    bud_r  <= bud_nxt;
    in_r   <= in_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word  = res_r;

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= 15'(NUM_BLOCKS * MIN_BLOCK)) else $error("used overflow");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept lost");
`endif
endmodule
